/* design/nearest_valid_depth_pixel_defines.svh */
// assertion macros for the top design file nearest_valid_depth_pixel.sv
`ifndef NEAREST_VALID_DEPTH_PIXEL_DEFINES_SVH
`define NEAREST_VALID_DEPTH_PIXEL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define NVDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define NVDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/nvdp_pkg.sv */
package nvdp_pkg;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int POINT_W = 96;
  localparam int DIST_W  = 21;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  localparam logic [10:0] MAX_COLUMNS = 11'(1 << COL_W);
  localparam logic [9:0]  MAX_ROWS    = 10'(1 << ROW_W);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] REG_NEAREST_ENABLE = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd2;

  localparam logic [2:0] STATUS_HIT     = 3'd0;
  localparam logic [2:0] STATUS_NEAREST = 3'd1;
  localparam logic [2:0] STATUS_NONE    = 3'd2;
  localparam logic [2:0] STATUS_OUTSIDE = 3'd3;
  localparam logic [2:0] STATUS_OFF     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } scan_tag_t;

  typedef struct packed {
    logic               valid;
    logic               nan;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [2*COL_W-1:0] du_sq;
    logic [2*ROW_W-1:0] dv_sq;
  } dist_tag_t;

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

endpackage

/* design/nvdp_store.sv */
module nvdp_store import nvdp_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [POINT_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [POINT_W-1:0] rd_data
);

  logic [POINT_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/nvdp_dist.sv */
module nvdp_dist import nvdp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  scan_tag_t        tag,
  input  logic             nan,
  input  logic [COL_W-1:0] q_col,
  input  logic [ROW_W-1:0] q_row,
  output dist_tag_t        dist_tag
);

  logic [COL_W:0]     du_full;
  logic [COL_W:0]     du_abs;
  logic [ROW_W:0]     dv_full;
  logic [ROW_W:0]     dv_abs;
  logic [COL_W-1:0]   du_mag;
  logic [ROW_W-1:0]   dv_mag;
  logic [2*COL_W-1:0] du_sq;
  logic [2*ROW_W-1:0] dv_sq;

  always_comb begin
    du_full = {1'b0, q_col} - {1'b0, tag.col};
    dv_full = {1'b0, q_row} - {1'b0, tag.row};
    du_abs  = du_full[COL_W] ? (~du_full + 1'b1) : du_full;
    dv_abs  = dv_full[ROW_W] ? (~dv_full + 1'b1) : dv_full;
    du_mag  = du_abs[COL_W-1:0];
    dv_mag  = dv_abs[ROW_W-1:0];
    du_sq   = {{COL_W{1'b0}}, du_mag} * {{COL_W{1'b0}}, du_mag};
    dv_sq   = {{ROW_W{1'b0}}, dv_mag} * {{ROW_W{1'b0}}, dv_mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_tag.valid <= 1'b0;
    end else begin
      dist_tag.valid <= tag.valid;
    end
    dist_tag.nan   <= nan;
    dist_tag.col   <= tag.col;
    dist_tag.row   <= tag.row;
    dist_tag.du_sq <= du_sq;
    dist_tag.dv_sq <= dv_sq;
  end

endmodule

/* design/nearest_valid_depth_pixel.sv */
// nearest valid pixel lookup over a stored organized point cloud
// command port: a beat is taken when start is high and busy is low.
//   mode load writes point_x/y/z at column/row (a negative one is dropped), no result;
//   loads may follow each other every cycle, busy stays low.
//   mode query returns exactly one result, marked by done for one cycle.
// paths of a query, from the accepting edge to the result:
//   outside the image: answered from idle, busy stays low
//   direct hit or invalid with search off: answered after the lookup read
//   nearest search over the clipped image of w by h pixels;
//   the raster scan reads one pixel a cycle from the point memory,
//   then a final read fetches the winning point
// busy is high from the accepting edge until the result is issued.
// config writes (cfg_we, cfg_index, cfg_data) take effect at once; the user must
// make them only while idle (not enforced); unlisted indexes are dropped.
// reset restores the register defaults and idles the control; the point
// memory is not cleared, so every queried pixel must be loaded first.
// results cannot be held off by the receiver: done is a one-cycle strobe.
`include "nearest_valid_depth_pixel_defines.svh"

module nearest_valid_depth_pixel import nvdp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic signed [10:0] column,
  input  logic signed [9:0]  row,
  input  logic [31:0]        point_x,
  input  logic [31:0]        point_y,
  input  logic [31:0]        point_z,
  output logic               done,
  output logic [31:0]        out_x,
  output logic [31:0]        out_y,
  output logic [31:0]        out_z,
  output logic [COL_W-1:0]   found_column,
  output logic [ROW_W-1:0]   found_row,
  output logic [2:0]         status
);

  state_t state, state_next;

  logic        nearest_enable;
  logic [10:0] image_width;
  logic [9:0]  image_height;
  logic [10:0] w_clip;
  logic [9:0]  h_clip;

  logic [COL_W-1:0] q_col;
  logic [ROW_W-1:0] q_row;

  logic [COL_W-1:0] scan_col;
  logic [ROW_W-1:0] scan_row;
  logic             col_last;
  logic             row_last;
  logic             scan_clear;
  logic             scan_step;

  logic               found;
  logic [DIST_W-1:0]  best_distance;
  logic [ADDR_W-1:0]  best_index;
  logic [DIST_W-1:0]  cand_dist;

  logic               mem_we;
  logic [ADDR_W-1:0]  rd_addr;
  logic [POINT_W-1:0] rd_data;
  logic               rd_nan;
  logic               accept;
  logic               query_outside;

  scan_tag_t p1;
  dist_tag_t p2;

  logic               res_valid_next;
  logic [POINT_W-1:0] res_point_next;
  logic [COL_W-1:0]   res_col_next;
  logic [ROW_W-1:0]   res_row_next;
  logic [2:0]         res_status_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign mem_we = accept && (mode == MODE_LOAD) && !column[10] && !row[9];

  assign w_clip = (image_width > MAX_COLUMNS) ? MAX_COLUMNS : image_width;
  assign h_clip = (image_height > MAX_ROWS) ? MAX_ROWS : image_height;
  assign query_outside = column[10] || row[9] ||
                         (column[10:0] >= w_clip) || (row[9:0] >= h_clip);

  assign col_last = ({1'b0, scan_col} == (w_clip - 11'd1));
  assign row_last = ({1'b0, scan_row} == (h_clip - 10'd1));
  assign rd_nan   = is_nan(rd_data[95:64]);
  assign cand_dist = {1'b0, p2.du_sq} + {{(DIST_W-2*ROW_W){1'b0}}, p2.dv_sq};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      nearest_enable <= 1'b1;
      image_width    <= 11'd640;
      image_height   <= 10'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEAREST_ENABLE: nearest_enable <= cfg_data[0];
        REG_IMAGE_WIDTH:    image_width    <= cfg_data;
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  nvdp_store u_store (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr ({row[ROW_W-1:0], column[COL_W-1:0]}),
    .wr_data ({point_x, point_y, point_z}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nvdp_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .tag      (p1),
    .nan      (rd_nan),
    .q_col    (q_col),
    .q_row    (q_row),
    .dist_tag (p2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    rd_addr         = {q_row, q_col};
    scan_clear      = 1'b0;
    scan_step       = 1'b0;
    res_valid_next  = 1'b0;
    res_point_next  = rd_data;
    res_col_next    = q_col;
    res_row_next    = q_row;
    res_status_next = STATUS_HIT;
    case (state)
      ST_IDLE: begin
        rd_addr = {row[ROW_W-1:0], column[COL_W-1:0]};
        if (accept && mode == MODE_QUERY) begin
          if (query_outside) begin
            res_valid_next  = 1'b1;
            res_point_next  = '0;
            res_col_next    = '0;
            res_row_next    = '0;
            res_status_next = STATUS_OUTSIDE;
          end else begin
            state_next = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (!rd_nan) begin
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end else if (!nearest_enable) begin
          res_valid_next  = 1'b1;
          res_status_next = STATUS_OFF;
          state_next      = ST_IDLE;
        end else begin
          scan_clear = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr   = {scan_row, scan_col};
        scan_step = 1'b1;
        if (col_last && row_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        rd_addr = best_index;
        if (!p1.valid && !p2.valid) begin
          if (found) begin
            state_next = ST_FETCH;
          end else begin
            res_valid_next  = 1'b1;
            res_point_next  = '0;
            res_col_next    = '0;
            res_row_next    = '0;
            res_status_next = STATUS_NONE;
            state_next      = ST_IDLE;
          end
        end
      end
      ST_FETCH: begin
        res_valid_next  = 1'b1;
        res_col_next    = best_index[COL_W-1:0];
        res_row_next    = best_index[ADDR_W-1:COL_W];
        res_status_next = STATUS_NEAREST;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_col <= column[COL_W-1:0];
      q_row <= row[ROW_W-1:0];
    end
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (rst || scan_clear) begin
      scan_col <= '0;
      scan_row <= '0;
    end else if (scan_step) begin
      if (col_last) begin
        scan_col <= '0;
        scan_row <= scan_row + 1'b1;
      end else begin
        scan_col <= scan_col + 1'b1;
      end
    end
  end

  // read tag lines up with the registered memory data
  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= '0;
    end else begin
      p1.valid <= (state == ST_SCAN);
      p1.col   <= scan_col;
      p1.row   <= scan_row;
    end
  end

  // running minimum, first in raster order wins a tie
  always_ff @(posedge clk) begin
    if (rst || scan_clear) begin
      found         <= 1'b0;
      best_distance <= '1;
      best_index    <= '0;
    end else if (p2.valid && !p2.nan && (!found || cand_dist < best_distance)) begin
      found         <= 1'b1;
      best_distance <= cand_dist;
      best_index    <= {p2.row, p2.col};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid_next;
    end
    if (res_valid_next) begin
      out_x        <= res_point_next[95:64];
      out_y        <= res_point_next[63:32];
      out_z        <= res_point_next[31:0];
      found_column <= res_col_next;
      found_row    <= res_row_next;
      status       <= res_status_next;
    end
  end

  `NVDP_ASSERT_NEXT(a_load_no_result, accept && mode == MODE_LOAD, !done, "load beat gave a result")
  `NVDP_ASSERT_NOW(a_scan_silent, state == ST_SCAN, !done, "result during scan")
  `NVDP_ASSERT_NEXT(a_fetch_result, state == ST_FETCH, done && status == STATUS_NEAREST, "fetch without nearest result")
  `NVDP_ASSERT_NOW(a_compare_in_scan, p2.valid, state == ST_SCAN || state == ST_DRAIN, "distance beat outside scan")
  `NVDP_ASSERT_NOW(a_no_write_busy, busy, !mem_we, "store written while busy")

endmodule

/* verif/tb_nearest_valid_depth_pixel.sv */
module tb_nearest_valid_depth_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  import nvdp_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int TOTAL_BEATS = 1800;
  localparam int STALL_LIMIT = 10000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [31:0]      x;
    logic [31:0]      y;
    logic [31:0]      z;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [2:0]       status;
  } pixel_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [10:0]        cfg_data;
  logic               start;
  logic               busy;
  logic               mode;
  logic signed [10:0] column;
  logic signed [9:0]  row;
  logic [31:0]        point_x;
  logic [31:0]        point_y;
  logic [31:0]        point_z;
  logic               done;
  logic [31:0]        out_x;
  logic [31:0]        out_y;
  logic [31:0]        out_z;
  logic [COL_W-1:0]   found_column;
  logic [ROW_W-1:0]   found_row;
  logic [2:0]         status;

  // shadow of the point memory and the registers
  logic [95:0]   pixel_cloud [int unsigned];
  bit            search_on = 1'b1;
  int            img_w = 640;
  int            img_h = 480;

  pixel_result_t pending_results [$];
  pixel_result_t oldest_result;

  int gap_max = 0;
  int stall_cycles = 0;
  int mismatches = 0;
  int beats_taken = 0;
  int loads_taken = 0;
  int queries_taken = 0;
  int ignored_loads = 0;
  int status_seen [5] = '{default: 0};

  nearest_valid_depth_pixel i_dut (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic bit x_is_nan(input logic [31:0] bits);
    return bits[30:23] == 8'hFF && bits[22:0] != 23'd0;
  endfunction

  function automatic logic [95:0] stored_point(input int unsigned addr);
    return pixel_cloud.exists(addr) ? pixel_cloud[addr] : 96'd0;
  endfunction

  function automatic pixel_result_t lookup_pixel(input logic signed [10:0] c,
                                                 input logic signed [9:0] r);
    pixel_result_t res;
    int w, h, du, dv, sq_dist, best_dist, best_addr;
    int unsigned addr;
    logic [95:0] pt;
    bit found;
    res = '0;
    found = 1'b0;
    best_dist = 0;
    best_addr = 0;
    w = (img_w > int'(MAX_COLUMNS)) ? int'(MAX_COLUMNS) : img_w;
    h = (img_h > int'(MAX_ROWS)) ? int'(MAX_ROWS) : img_h;
    if (c < 0 || r < 0 || int'(c) >= w || int'(r) >= h) begin
      res.status = STATUS_OUTSIDE;
      return res;
    end
    addr = int'(r) * int'(MAX_COLUMNS) + int'(c);
    pt = stored_point(addr);
    if (!x_is_nan(pt[95:64]) || !search_on) begin
      {res.x, res.y, res.z} = pt;
      res.col = c[COL_W-1:0];
      res.row = r[ROW_W-1:0];
      res.status = x_is_nan(pt[95:64]) ? STATUS_OFF : STATUS_HIT;
      return res;
    end
    // raster scan, strict compare keeps the first pixel on a tie
    for (int i = 0; i < h; i++) begin
      for (int j = 0; j < w; j++) begin
        addr = i * int'(MAX_COLUMNS) + j;
        pt = stored_point(addr);
        if (!x_is_nan(pt[95:64])) begin
          du = int'(c) - j;
          dv = int'(r) - i;
          sq_dist = du * du + dv * dv;
          if (!found || sq_dist < best_dist) begin
            found = 1'b1;
            best_dist = sq_dist;
            best_addr = addr;
          end
        end
      end
    end
    if (!found) begin
      res.status = STATUS_NONE;
      return res;
    end
    {res.x, res.y, res.z} = stored_point(best_addr);
    res.col = COL_W'(best_addr % int'(MAX_COLUMNS));
    res.row = ROW_W'(best_addr / int'(MAX_COLUMNS));
    res.status = STATUS_NEAREST;
    return res;
  endfunction

  function automatic void apply_beat(input logic m, input logic signed [10:0] c,
                                     input logic signed [9:0] r, input logic [95:0] pt);
    pixel_result_t res;
    if (m == MODE_LOAD) begin
      if (c < 0 || r < 0) begin
        ignored_loads++;
      end else begin
        pixel_cloud[int'(r) * int'(MAX_COLUMNS) + int'(c)] = pt;
        loads_taken++;
        beats_taken++;
      end
    end else begin
      res = lookup_pixel(c, r);
      pending_results.push_back(res);
      status_seen[res.status]++;
      queries_taken++;
      beats_taken++;
    end
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] random_x(input int nan_pct);
    logic [31:0] v;
    v = random_word();
    if ($urandom_range(1, 100) <= nan_pct) begin
      v[30:23] = 8'hFF;
      if (v[22:0] == 23'd0) v[0] = 1'b1;
    end else if (v[30:23] == 8'hFF) begin
      v[22:0] = 23'd0;
    end
    return v;
  endfunction

  function automatic logic [95:0] random_point(input int nan_pct);
    return {random_x(nan_pct), random_word(), random_word()};
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no query waiting");
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("out_x", out_x, oldest_result.x);
        check_field("out_y", out_y, oldest_result.y);
        check_field("out_z", out_z, oldest_result.z);
        check_field("found_column", 32'(found_column), 32'(oldest_result.col));
        check_field("found_row", 32'(found_row), 32'(oldest_result.row));
        check_field("status", 32'(status), 32'(oldest_result.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat and no result for %0d cycles", STALL_LIMIT);
      $display("** nearest_valid_depth_pixel: FAILED **");
      $finish;
    end
  end

  // returns right after the accepting edge, start still high
  task automatic send_beat(input logic m, input logic signed [10:0] c,
                           input logic signed [9:0] r, input logic [95:0] pt);
    int gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    mode <= m;
    column <= c;
    row <= r;
    {point_x, point_y, point_z} <= pt;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_beat(m, c, r, pt);
  endtask

  task automatic query_at(input logic signed [10:0] c, input logic signed [9:0] r);
    send_beat(MODE_QUERY, c, r, {$urandom(), $urandom(), $urandom()});
  endtask

  task automatic fill_image(input int w, input int h, input int nan_pct);
    for (int rr = 0; rr < h; rr++) begin
      for (int cc = 0; cc < w; cc++) send_beat(MODE_LOAD, 11'(cc), 10'(rr), random_point(nan_pct));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [10:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_config(input bit enable, input int w, input int h);
    wait_idle();
    write_register(REG_NEAREST_ENABLE, 11'(enable));
    write_register(REG_IMAGE_WIDTH, 11'(w));
    write_register(REG_IMAGE_HEIGHT, 11'(h));
    search_on = enable;
    img_w = w;
    img_h = h;
  endtask

  task automatic test_reset_values();
    gap_max = 4;
    send_beat(MODE_LOAD, 11'sd0, 10'sd0, {32'h3F80_0000, 32'hFFFF_FFFF, 32'h0000_0000});
    send_beat(MODE_LOAD, 11'sd639, 10'sd479, {32'hFF80_0000, 32'h0000_0000, 32'hFFFF_FFFF});
    query_at(639, 479);
    query_at(0, 0);
    query_at(640, 479);
    query_at(639, 480);
    query_at(-1, -1);
    query_at(-1024, -512);
    query_at(1023, 511);
    // unused register index must not touch anything
    wait_idle();
    write_register(REG_SPARE, 11'h7FF);
    query_at(640, 0);
    query_at(639, 479);
  endtask

  task automatic test_small_image();
    gap_max = 4;
    write_config(1'b1, 3, 2);
    send_beat(MODE_LOAD, 0, 0, {32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_0000});
    send_beat(MODE_LOAD, 1, 0, {32'h7F80_0001, random_word(), random_word()});
    send_beat(MODE_LOAD, 2, 0, {32'h7F80_0000, random_word(), random_word()});
    send_beat(MODE_LOAD, 0, 1, {32'hFF80_0000, random_word(), random_word()});
    send_beat(MODE_LOAD, 1, 1, {32'hFFFF_FFFF, random_word(), random_word()});
    send_beat(MODE_LOAD, 2, 1, {32'h7FC0_0000, random_word(), random_word()});
    query_at(0, 0);
    query_at(1, 1);
    // two valid pixels at distance one, raster order decides
    query_at(1, 0);
    query_at(2, 1);
    query_at(2, 0);
    write_config(1'b0, 3, 2);
    query_at(1, 0);
    query_at(0, 1);
    write_config(1'b1, 3, 2);
    send_beat(MODE_LOAD, 0, 0, {32'hFFC0_0000, random_word(), random_word()});
    send_beat(MODE_LOAD, 2, 0, {32'h7F80_0001, random_word(), random_word()});
    send_beat(MODE_LOAD, 0, 1, {32'h7FFF_FFFF, random_word(), random_word()});
    query_at(2, 1);
    query_at(0, 0);
  endtask

  task automatic test_wide_row();
    gap_max = $urandom_range(0, 1) ? 4 : 0;
    write_config(1'b1, 2047, 1);
    fill_image(1024, 1, 25);
    // negative coordinates are dropped, never wrapped into the store
    send_beat(MODE_LOAD, -1, 0, random_point(100));
    send_beat(MODE_LOAD, -1024, 0, random_point(100));
    send_beat(MODE_LOAD, 1023, -1, random_point(100));
    send_beat(MODE_LOAD, 0, -512, random_point(100));
    send_beat(MODE_LOAD, -1, -1, random_point(100));
    query_at(1023, 0);
    query_at(0, 0);
    query_at(0, 1);
    query_at(-1, 0);
    repeat (16) query_at(11'($urandom_range(0, 1023)), 0);
    write_config(1'b1, 1024, 1);
    repeat (4) query_at(11'($urandom_range(0, 1023)), 0);
    write_config(1'b0, 1024, 1);
    repeat (4) query_at(11'($urandom_range(0, 1023)), 0);
    write_config(1'b1, 1, 1);
    query_at(0, 0);
    query_at(1, 0);
  endtask

  task automatic test_tall_column();
    gap_max = $urandom_range(0, 1) ? 4 : 0;
    write_config(1'b1, 1, 1023);
    fill_image(1, 512, 25);
    send_beat(MODE_LOAD, 0, -1, random_point(100));
    send_beat(MODE_LOAD, 0, -512, random_point(100));
    send_beat(MODE_LOAD, -1024, 511, random_point(100));
    send_beat(MODE_LOAD, -2, 5, random_point(100));
    query_at(0, 511);
    query_at(0, 0);
    query_at(1, 0);
    query_at(0, -1);
    repeat (16) query_at(0, 10'($urandom_range(0, 511)));
    write_config(1'b1, 1, 512);
    repeat (4) query_at(0, 10'($urandom_range(0, 511)));
  endtask

  task automatic test_empty_image();
    gap_max = 4;
    write_config(1'b1, 0, 480);
    query_at(0, 0);
    query_at(5, 5);
    write_config(1'b1, 640, 0);
    query_at(0, 0);
    write_config(1'b0, 0, 0);
    query_at(0, 0);
  endtask

  task automatic test_random_images();
    int w, h, nan_pct, ops, pick;
    logic signed [10:0] c;
    logic signed [9:0] r;
    while (beats_taken < TOTAL_BEATS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1) != 0) w = 0;
        else h = 0;
      end
      case ($urandom_range(0, 3))
        0: nan_pct = 0;
        1: nan_pct = 25;
        2: nan_pct = 60;
        default: nan_pct = 100;
      endcase
      gap_max = $urandom_range(0, 1) ? 4 : 0;
      write_config($urandom_range(0, 3) != 0, w, h);
      fill_image(w, h, nan_pct);
      ops = $urandom_range(20, 60);
      repeat (ops) begin
        pick = $urandom_range(0, 99);
        c = 11'($urandom());
        r = 10'($urandom());
        if (pick < 35 && w > 0 && h > 0) begin
          send_beat(MODE_LOAD, 11'($urandom_range(0, w - 1)), 10'($urandom_range(0, h - 1)),
                    random_point(nan_pct));
        end else if (pick < 40) begin
          send_beat(MODE_LOAD, 11'($urandom_range(0, 1023)), 10'($urandom_range(0, 511)),
                    random_point(nan_pct));
        end else if (pick < 45) begin
          case ($urandom_range(0, 2))
            0: c[10] = 1'b1;
            1: r[9] = 1'b1;
            default: {c[10], r[9]} = 2'b11;
          endcase
          send_beat(MODE_LOAD, c, r, random_point(50));
        end else if (pick < 85 && w > 0 && h > 0) begin
          query_at(11'($urandom_range(0, w - 1)), 10'($urandom_range(0, h - 1)));
        end else begin
          query_at(c, r);
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_NEAREST_ENABLE;
    cfg_data = '0;
    start = 1'b0;
    mode = MODE_LOAD;
    column = '0;
    row = '0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_small_image();
    test_wide_row();
    test_tall_column();
    test_empty_image();
    test_random_images();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d beats: %0d loads, %0d queries, %0d dropped loads",
             beats_taken, loads_taken, queries_taken, ignored_loads);
    $display("answers: hit %0d, nearest %0d, none valid %0d, outside %0d, search off %0d",
             status_seen[STATUS_HIT], status_seen[STATUS_NEAREST], status_seen[STATUS_NONE],
             status_seen[STATUS_OUTSIDE], status_seen[STATUS_OFF]);
    if (mismatches == 0) begin
      $display("** nearest_valid_depth_pixel: PASSED **");
    end else begin
      $display("** nearest_valid_depth_pixel: FAILED **");
    end
    $finish;
  end

endmodule

/* nearest_valid_depth_pixel.f */
+incdir+design
design/nvdp_pkg.sv
design/nvdp_store.sv
design/nvdp_dist.sv
design/nearest_valid_depth_pixel.sv
verif/tb_nearest_valid_depth_pixel.sv
